// ===== rtl/core/psarx_pkg.sv =====
// Shared types and constants for the extended parabolic stop-and-reverse unit.
// No dependencies.
package psarx_pkg;

	localparam int PRICE_W   = 32;
	localparam int FACTOR_W  = 16;
	localparam int START_W   = PRICE_W + 1;
	localparam int CFG_IDX_W = 3;

	typedef logic [PRICE_W-1:0]  price_t;
	typedef logic [FACTOR_W-1:0] factor_t;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_MODE  = 3'd0,
		REG_REV_OFFSET  = 3'd1,
		REG_LONG_INIT   = 3'd2,
		REG_LONG_STEP   = 3'd3,
		REG_LONG_MAX    = 3'd4,
		REG_SHORT_INIT  = 3'd5,
		REG_SHORT_STEP  = 3'd6,
		REG_SHORT_MAX   = 3'd7
	} cfg_reg_t;

	localparam factor_t AF_INIT_RST = factor_t'(1311);
	localparam factor_t AF_STEP_RST = factor_t'(1311);
	localparam factor_t AF_MAX_RST  = factor_t'(13107);

	typedef enum logic [1:0] {
		PHASE_EMPTY = 2'd0,
		PHASE_FIRST = 2'd1,
		PHASE_RUN   = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_EVAL,
		ST_MUL_OFS,
		ST_APPLY_OFS,
		ST_SETUP_MOVE,
		ST_MUL_MOVE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic   new_series;
		price_t high_price;
		price_t low_price;
	} in_item_t;

	typedef struct packed {
		logic signed [START_W-1:0] stop_value;
		logic                      is_short;
	} out_item_t;

	typedef struct packed {
		logic load;        // capture the bar
		logic record;      // first bar of a series: keep it as prior bar
		logic init;        // second bar: set direction and start stop
		logic eval;        // reversal test, extreme and factor update
		logic mul_go;      // shared multiplier fires
		logic apply_ofs;   // add or subtract the reversal offset
		logic setup_move;  // distance and factor toward the extreme
		logic finish;      // clamp, commit state, load result
	} dp_cmd_t;

	typedef struct packed {
		logic first_bar;
		logic phase_first;
		logic rev;
		logic out_busy;
	} dp_status_t;

endpackage

// ===== rtl/core/parabolic_sar_extended_unit.sv =====
// Extended parabolic stop-and-reverse unit, top level.
// Depends on psarx_pkg, psarx_ctrl, psarx_datapath.
//
// Input channel (in_valid/in_stall/in_data) takes one price bar per item:
// new_series, high_price, low_price (unsigned Q16.16). An item is taken when
// in_valid is high and in_stall is low. The first bar of a series gives no
// result; every later bar gives one result on out_valid/out_stall/out_data:
// the stop in signed Q17.16 (negative while short) and is_short.
// A bar passes INIT (second bar of a series only), EVAL, MUL_OFS and
// APPLY_OFS (only on a reversal), SETUP_MOVE, MUL_MOVE and FINISH, which
// loads the result register; the next bar is accepted once the sequencer is
// back in IDLE. A first bar is only recorded in IDLE. The period is set by
// the sequencer and the single shared 32x16 multiplier, used once for the
// move toward the extreme point and, on a reversal, once more for the offset.
// The result register frees the input side: a new bar is accepted while a
// result still waits. If the receiver stalls, the next result is held back
// in its final step until the register is taken. The user must write the
// configuration (cfg_we/cfg_index/cfg_data) only while idle; the unit
// does not enforce it. Reset clears series state, loads default factors.
module parabolic_sar_extended_unit import psarx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [START_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	psarx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	psarx_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/core/psarx_mul.sv =====
// Shared fractional multiplier: registered floor(a * f / 2^FACTOR_W).
// Depends on psarx_pkg.
module psarx_mul import psarx_pkg::*; (
	input  logic    clk,
	input  logic    go,
	input  price_t  a,
	input  factor_t f,
	output price_t  prod
);

	logic [PRICE_W+FACTOR_W-1:0] full;
	price_t prod_q;

	assign full = a * f;
	assign prod = prod_q;

	always_ff @(posedge clk) begin
		if (go) begin
			prod_q <= full[PRICE_W+FACTOR_W-1:FACTOR_W];
		end
	end

endmodule

// ===== rtl/core/psarx_datapath.sv =====
// Datapath: configuration registers, indicator state, working stop and result register.
// Depends on psarx_pkg and psarx_mul.
module psarx_datapath import psarx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [START_W-1:0]   cfg_data,
	input  in_item_t             in_data,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data
);

	function automatic price_t max3(price_t a, price_t b, price_t c);
		price_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic price_t min3(price_t a, price_t b, price_t c);
		price_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	// configuration
	logic [START_W-1:0] start_q;
	factor_t ofs_q, linit_q, lstep_q, lmax_q, sinit_q, sstep_q, smax_q;

	// indicator state
	phase_t  phase_q;
	logic    pos_q;     // 1 = long
	price_t  ep_q, stop_q, ph_q, pl_q;
	factor_t lf_q, sf_q;

	// per-item working registers
	price_t  h_q, l_q, w_q, res_q, mul_a_q;
	factor_t mul_f_q;
	logic    up_q;
	price_t  prod;

	logic      out_valid_q;
	out_item_t out_q;

	factor_t linit, lstep, sinit, sstep, lf_next, sf_next, fac;
	logic [FACTOR_W:0] lf_sum, sf_sum;
	logic signed [START_W-1:0] up_diff, down_diff;
	logic [START_W-1:0] neg_start;
	logic auto_long, rev, up_move;
	price_t s0_long, s0_short, ofs_dn, ep_gap, moved, clamped;
	logic [PRICE_W:0] ofs_sum, res_ext;
	price_t ofs_up;

	psarx_mul u_mul (
		.clk  (clk),
		.go   (cmd.mul_go),
		.a    (mul_a_q),
		.f    (mul_f_q),
		.prod (prod)
	);

	always_comb begin
		linit = (linit_q < lmax_q) ? linit_q : lmax_q;
		lstep = (lstep_q < lmax_q) ? lstep_q : lmax_q;
		sinit = (sinit_q < smax_q) ? sinit_q : smax_q;
		sstep = (sstep_q < smax_q) ? sstep_q : smax_q;

		up_diff   = $signed({1'b0, h_q}) - $signed({1'b0, ph_q});
		down_diff = $signed({1'b0, pl_q}) - $signed({1'b0, l_q});
		auto_long = !((down_diff > up_diff) && (down_diff > 0));
		neg_start = -start_q;

		rev      = pos_q ? (l_q <= stop_q) : (h_q >= stop_q);
		s0_long  = max3(ep_q, ph_q, h_q);
		s0_short = min3(ep_q, pl_q, l_q);
		lf_sum   = {1'b0, lf_q} + {1'b0, lstep};
		sf_sum   = {1'b0, sf_q} + {1'b0, sstep};
		lf_next  = (lf_sum > {1'b0, lmax_q}) ? lmax_q : lf_sum[FACTOR_W-1:0];
		sf_next  = (sf_sum > {1'b0, smax_q}) ? smax_q : sf_sum[FACTOR_W-1:0];

		// offset grows the stop into a short, shrinks it into a long
		ofs_sum = {1'b0, w_q} + {1'b0, prod};
		ofs_up  = ofs_sum[PRICE_W] ? '1 : ofs_sum[PRICE_W-1:0];
		ofs_dn  = w_q - prod;

		up_move = ep_q >= w_q;
		ep_gap  = up_move ? (ep_q - w_q) : (w_q - ep_q);
		fac     = pos_q ? lf_q : sf_q;

		moved   = up_q ? (w_q + prod) : (w_q - prod);
		clamped = pos_q ? min3(moved, pl_q, l_q) : max3(moved, ph_q, h_q);
		res_ext = {1'b0, res_q};
	end

	assign status.first_bar   = in_data.new_series || (phase_q == PHASE_EMPTY);
	assign status.phase_first = (phase_q == PHASE_FIRST);
	assign status.rev         = rev;
	assign status.out_busy    = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			ofs_q   <= '0;
			linit_q <= AF_INIT_RST;
			lstep_q <= AF_STEP_RST;
			lmax_q  <= AF_MAX_RST;
			sinit_q <= AF_INIT_RST;
			sstep_q <= AF_STEP_RST;
			smax_q  <= AF_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_MODE: start_q <= cfg_data;
				REG_REV_OFFSET: ofs_q   <= cfg_data[FACTOR_W-1:0];
				REG_LONG_INIT:  linit_q <= cfg_data[FACTOR_W-1:0];
				REG_LONG_STEP:  lstep_q <= cfg_data[FACTOR_W-1:0];
				REG_LONG_MAX:   lmax_q  <= cfg_data[FACTOR_W-1:0];
				REG_SHORT_INIT: sinit_q <= cfg_data[FACTOR_W-1:0];
				REG_SHORT_STEP: sstep_q <= cfg_data[FACTOR_W-1:0];
				REG_SHORT_MAX:  smax_q  <= cfg_data[FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_EMPTY;
			pos_q   <= 1'b1;
			ep_q    <= '0;
			stop_q  <= '0;
			lf_q    <= '0;
			sf_q    <= '0;
			ph_q    <= '0;
			pl_q    <= '0;
		end else begin
			if (cmd.record) begin
				ph_q    <= in_data.high_price;
				pl_q    <= in_data.low_price;
				phase_q <= PHASE_FIRST;
			end
			if (cmd.init) begin
				if (start_q == '0) begin
					pos_q  <= auto_long;
					ep_q   <= auto_long ? h_q : l_q;
					stop_q <= auto_long ? pl_q : ph_q;
				end else if (!start_q[START_W-1]) begin
					pos_q  <= 1'b1;
					ep_q   <= h_q;
					stop_q <= start_q[PRICE_W-1:0];
				end else begin
					pos_q  <= 1'b0;
					ep_q   <= l_q;
					// the most negative start saturates to the largest price
					stop_q <= neg_start[PRICE_W] ? '1 : neg_start[PRICE_W-1:0];
				end
				lf_q    <= linit;
				sf_q    <= sinit;
				// the second bar serves as its own prior bar
				ph_q    <= h_q;
				pl_q    <= l_q;
				phase_q <= PHASE_RUN;
			end
			if (cmd.eval) begin
				if (rev) begin
					pos_q <= !pos_q;
					ep_q  <= pos_q ? l_q : h_q;
					if (pos_q) begin
						sf_q <= sinit;
					end else begin
						lf_q <= linit;
					end
				end else if (pos_q && (h_q > ep_q)) begin
					ep_q <= h_q;
					lf_q <= lf_next;
				end else if (!pos_q && (l_q < ep_q)) begin
					ep_q <= l_q;
					sf_q <= sf_next;
				end
			end
			if (cmd.finish) begin
				stop_q <= clamped;
				ph_q   <= h_q;
				pl_q   <= l_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			h_q <= in_data.high_price;
			l_q <= in_data.low_price;
		end
		if (cmd.eval) begin
			if (rev) begin
				w_q     <= pos_q ? s0_long : s0_short;
				mul_a_q <= pos_q ? s0_long : s0_short;
				mul_f_q <= ofs_q;
			end else begin
				w_q   <= stop_q;
				res_q <= stop_q;
			end
		end
		if (cmd.apply_ofs) begin
			// pos_q already holds the new direction here
			w_q   <= pos_q ? ofs_dn : ofs_up;
			res_q <= pos_q ? ofs_dn : ofs_up;
		end
		if (cmd.setup_move) begin
			mul_a_q <= ep_gap;
			mul_f_q <= fac;
			up_q    <= up_move;
		end
		if (cmd.finish) begin
			out_q.stop_value <= pos_q ? $signed(res_ext) : -$signed(res_ext);
			out_q.is_short   <= !pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_finish_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> phase_q == PHASE_RUN)
		else $error("result committed outside a running series");

	a_ofs_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply_ofs |-> $past(cmd.mul_go))
		else $error("offset applied without a fresh product");

	a_stop_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (pos_q ? (stop_q <= l_q) : (stop_q >= h_q)))
		else $error("stop not limited by the current bar");

	a_finish_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !status.out_busy)
		else $error("result register overwritten while waiting");
`endif

endmodule

// ===== rtl/core/psarx_ctrl.sv =====
// Sequencer for one bar: accept, setup, reversal offset, move toward extreme, commit.
// Depends on psarx_pkg.
module psarx_ctrl import psarx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !status.first_bar) begin
					state_d = status.phase_first ? ST_INIT : ST_EVAL;
				end
			end
			ST_INIT:       state_d = ST_EVAL;
			ST_EVAL:       state_d = status.rev ? ST_MUL_OFS : ST_SETUP_MOVE;
			ST_MUL_OFS:    state_d = ST_APPLY_OFS;
			ST_APPLY_OFS:  state_d = ST_SETUP_MOVE;
			ST_SETUP_MOVE: state_d = ST_MUL_MOVE;
			ST_MUL_MOVE:   state_d = ST_FINISH;
			ST_FINISH: begin
				if (!status.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.load   = in_valid;
				cmd.record = in_valid && status.first_bar;
			end
			ST_INIT:       cmd.init = 1'b1;
			ST_EVAL:       cmd.eval = 1'b1;
			ST_MUL_OFS:    cmd.mul_go = 1'b1;
			ST_APPLY_OFS:  cmd.apply_ofs = 1'b1;
			ST_SETUP_MOVE: cmd.setup_move = 1'b1;
			ST_MUL_MOVE:   cmd.mul_go = 1'b1;
			ST_FINISH:     cmd.finish = !status.out_busy;
			default: ;
		endcase
	end

endmodule

// ===== sim/parabolic_sar_extended_unit_checker.sv =====
`timescale 1ns / 100ps
// Stop-value scoreboard for parabolic_sar_extended_unit: follows register writes and
// accepted bars, predicts each stop and compares it with the delivered results.
// Depends on psarx_pkg.
module parabolic_sar_extended_unit_checker import psarx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [START_W-1:0]   cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_data,
	output int                   errors,
	output int                   waiting,
	output int                   stops_checked,
	output int                   shorts_seen
);

	typedef logic [63:0] wide_t;
	localparam wide_t PRICE_TOP = (wide_t'(1) << PRICE_W) - 1;

	// register copy
	logic [START_W-1:0] start_cfg;
	factor_t offset_cfg;
	factor_t linit_cfg, lstep_cfg, lmax_cfg;
	factor_t sinit_cfg, sstep_cfg, smax_cfg;

	// series state
	phase_t  phase;
	logic    go_long;
	price_t  extreme, stop_lvl, last_high, last_low;
	factor_t long_af, short_af;

	out_item_t pending_stops[$];
	int n_err = 0;
	int n_wait = 0;
	int n_checked = 0;
	int n_short = 0;

	assign errors        = n_err;
	assign waiting       = n_wait;
	assign stops_checked = n_checked;
	assign shorts_seen   = n_short;

	function automatic wide_t frac_of(wide_t a, wide_t f);
		return (a * f) >> FACTOR_W;
	endfunction

	function automatic wide_t wmin(wide_t a, wide_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic wide_t wmax(wide_t a, wide_t b);
		return (a > b) ? a : b;
	endfunction

	// truncation is toward the old stop
	function automatic wide_t step_to(wide_t s, wide_t ep, wide_t af);
		if (ep >= s)
			return s + frac_of(ep - s, af);
		return s - frac_of(s - ep, af);
	endfunction

	task automatic take_bar(input in_item_t bar, output bit gives, output out_item_t stop);
		wide_t hi_p, lo_p, ph, pl, s, res, li, si, af_sum, neg;
		logic signed [63:0] up, down;
		logic [START_W-1:0] mag;
		hi_p = bar.high_price;
		lo_p = bar.low_price;
		li = wmin(linit_cfg, lmax_cfg);
		si = wmin(sinit_cfg, smax_cfg);
		gives = 1'b0;
		stop = '0;
		if (bar.new_series || phase == PHASE_EMPTY) begin
			last_high = bar.high_price;
			last_low = bar.low_price;
			phase = PHASE_FIRST;
		end else begin
			if (phase == PHASE_FIRST) begin
				if (start_cfg == '0) begin
					up = signed'(hi_p - wide_t'(last_high));
					down = signed'(wide_t'(last_low) - lo_p);
					go_long = !(down > up && down > 0);
					extreme = go_long ? bar.high_price : bar.low_price;
					stop_lvl = go_long ? last_low : last_high;
				end else if (!start_cfg[START_W-1]) begin
					go_long = 1'b1;
					extreme = bar.high_price;
					stop_lvl = start_cfg[PRICE_W-1:0];
				end else begin
					go_long = 1'b0;
					extreme = bar.low_price;
					mag = -start_cfg;
					stop_lvl = price_t'(wmin(mag, PRICE_TOP));
				end
				long_af = factor_t'(li);
				short_af = factor_t'(si);
				ph = hi_p;
				pl = lo_p;
				phase = PHASE_RUN;
			end else begin
				ph = last_high;
				pl = last_low;
			end

			s = stop_lvl;
			if (go_long) begin
				if (lo_p <= s) begin
					go_long = 1'b0;
					s = wmax(wmax(extreme, ph), hi_p);
					s = s + frac_of(s, offset_cfg);
					if (s > PRICE_TOP)
						s = PRICE_TOP;
					res = s;
					short_af = factor_t'(si);
					extreme = bar.low_price;
					s = step_to(s, extreme, short_af);
					s = wmax(wmax(s, ph), hi_p);
				end else begin
					res = s;
					if (hi_p > extreme) begin
						extreme = bar.high_price;
						af_sum = wide_t'(long_af) + wmin(lstep_cfg, lmax_cfg);
						long_af = factor_t'(wmin(af_sum, lmax_cfg));
					end
					s = step_to(s, extreme, long_af);
					s = wmin(wmin(s, pl), lo_p);
				end
			end else begin
				if (hi_p >= s) begin
					go_long = 1'b1;
					s = wmin(wmin(extreme, pl), lo_p);
					s = s - frac_of(s, offset_cfg);
					res = s;
					long_af = factor_t'(li);
					extreme = bar.high_price;
					s = step_to(s, extreme, long_af);
					s = wmin(wmin(s, pl), lo_p);
				end else begin
					res = s;
					if (lo_p < extreme) begin
						extreme = bar.low_price;
						af_sum = wide_t'(short_af) + wmin(sstep_cfg, smax_cfg);
						short_af = factor_t'(wmin(af_sum, smax_cfg));
					end
					s = step_to(s, extreme, short_af);
					s = wmax(wmax(s, ph), hi_p);
				end
			end

			stop_lvl = price_t'(s);
			last_high = bar.high_price;
			last_low = bar.low_price;
			neg = wide_t'(0) - res;
			stop.stop_value = go_long ? res[START_W-1:0] : neg[START_W-1:0];
			stop.is_short = !go_long;
			gives = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		bit gives;
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			start_cfg = '0;
			offset_cfg = '0;
			linit_cfg = AF_INIT_RST;
			lstep_cfg = AF_STEP_RST;
			lmax_cfg = AF_MAX_RST;
			sinit_cfg = AF_INIT_RST;
			sstep_cfg = AF_STEP_RST;
			smax_cfg = AF_MAX_RST;
			phase = PHASE_EMPTY;
			go_long = 1'b1;
			extreme = '0;
			stop_lvl = '0;
			last_high = '0;
			last_low = '0;
			long_af = '0;
			short_af = '0;
			pending_stops.delete();
			n_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = out_data;
				if (pending_stops.size() == 0) begin
					n_err++;
					$display("%0t: unexpected result stop %0d is_short %0b", $time,
						got.stop_value, got.is_short);
				end else begin
					want = pending_stops.pop_front();
					n_checked++;
					if (got.is_short)
						n_short++;
					if (got.stop_value !== want.stop_value) begin
						n_err++;
						$display("%0t: stop_value expected %0d got %0d", $time,
							want.stop_value, got.stop_value);
					end
					if (got.is_short !== want.is_short) begin
						n_err++;
						$display("%0t: is_short expected %0b got %0b", $time,
							want.is_short, got.is_short);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_START_MODE: start_cfg = cfg_data;
					REG_REV_OFFSET: offset_cfg = cfg_data[FACTOR_W-1:0];
					REG_LONG_INIT:  linit_cfg = cfg_data[FACTOR_W-1:0];
					REG_LONG_STEP:  lstep_cfg = cfg_data[FACTOR_W-1:0];
					REG_LONG_MAX:   lmax_cfg = cfg_data[FACTOR_W-1:0];
					REG_SHORT_INIT: sinit_cfg = cfg_data[FACTOR_W-1:0];
					REG_SHORT_STEP: sstep_cfg = cfg_data[FACTOR_W-1:0];
					REG_SHORT_MAX:  smax_cfg = cfg_data[FACTOR_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				take_bar(in_data, gives, want);
				if (gives)
					pending_stops.push_back(want);
			end
			n_wait = pending_stops.size();
		end
	end

endmodule

// ===== sim/parabolic_sar_extended_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench top for parabolic_sar_extended_unit: clock, reset, register settings,
// directed and random-walk price bars, stall patterns and the verdict.
// Depends on psarx_pkg, the unit and parabolic_sar_extended_unit_checker.
module parabolic_sar_extended_unit_test import psarx_pkg::*;;

	localparam int  SETTING_COUNT   = 9;
	localparam int  BARS_PER_SETTING = 200;
	localparam int  CYCLE_LIMIT     = 500000;
	localparam longint PRICE_TOP    = 64'hFFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [START_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	int stop_errors, stops_waiting, stops_checked, shorts_seen;

	int cycle_count = 0;
	int bars_sent = 0;
	int burst_left = 0;
	int gap_mode = 0;
	int stall_mode = 0;
	int run_left = 0;
	bit stall_on = 1'b0;

	// random walk of the current series
	longint walk_mid, walk_span, walk_drift;

	parabolic_sar_extended_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	parabolic_sar_extended_unit_checker stop_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.errors        (stop_errors),
		.waiting       (stops_waiting),
		.stops_checked (stops_checked),
		.shorts_seen   (shorts_seen)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d stops outstanding", cycle_count,
				stops_waiting);
			$display("[parabolic_sar_extended_unit] ERROR");
			$finish;
		end
	end

	// receiver: alternating stall and free runs, lengths set by stall_mode (0: no stall)
	always @(negedge clk) begin
		if (run_left == 0) begin
			stall_on = !stall_on;
			if (stall_mode == 0) begin
				stall_on = 1'b0;
				run_left = 16;
			end else if (stall_on)
				run_left = (stall_mode == 1) ? $urandom_range(1, 3) : $urandom_range(1, 12);
			else
				run_left = (stall_mode == 1) ? $urandom_range(2, 10) : $urandom_range(1, 4);
		end
		run_left--;
		out_stall <= stall_on;
	end

	function automatic in_item_t mk(logic ns, price_t hi_p, price_t lo_p);
		in_item_t b;
		b.new_series = ns;
		b.high_price = hi_p;
		b.low_price = lo_p;
		return b;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic drive_bar(input in_item_t b);
		int gap;
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		bars_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = (gap_mode == 0) ? 0 :
				(gap_mode == 1) ? $urandom_range(1, 3) : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (stops_waiting != 0) @(negedge clk);
		// a first bar gives no result; it is recorded when it is accepted
		repeat (16) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [START_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic apply_regs(input logic [START_W-1:0] sv, input factor_t ofs,
			input factor_t li, input factor_t ls, input factor_t lm,
			input factor_t si, input factor_t ss, input factor_t sm);
		write_reg(REG_START_MODE, sv);
		write_reg(REG_REV_OFFSET, START_W'(ofs));
		write_reg(REG_LONG_INIT, START_W'(li));
		write_reg(REG_LONG_STEP, START_W'(ls));
		write_reg(REG_LONG_MAX, START_W'(lm));
		write_reg(REG_SHORT_INIT, START_W'(si));
		write_reg(REG_SHORT_STEP, START_W'(ss));
		write_reg(REG_SHORT_MAX, START_W'(sm));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic next_walk(input logic ns, output in_item_t b);
		longint hi_v, lo_v, tmp;
		if ($urandom_range(0, 7) == 0)
			walk_drift = -walk_drift;
		walk_mid = walk_mid + walk_drift
			+ longint'($urandom_range(0, 2 * walk_span)) - walk_span;
		if (walk_mid < 0)
			walk_mid = 0;
		if (walk_mid > PRICE_TOP)
			walk_mid = PRICE_TOP;
		hi_v = walk_mid + longint'($urandom_range(0, walk_span));
		lo_v = walk_mid - longint'($urandom_range(0, walk_span));
		if (hi_v > PRICE_TOP)
			hi_v = PRICE_TOP;
		if (lo_v < 0)
			lo_v = 0;
		// now and then a bar with its high below its low
		if ($urandom_range(0, 19) == 0) begin
			tmp = hi_v;
			hi_v = lo_v;
			lo_v = tmp;
		end
		b = mk(ns, price_t'(hi_v), price_t'(lo_v));
	endtask

	initial begin
		in_item_t b;
		int target, series_len;
		logic [START_W-1:0] sv;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int k = 0; k < SETTING_COUNT; k++) begin
			gap_mode = k % 3;
			stall_mode = (k + 1) % 3;
			if (k > 0)
				settle();
			case (k)
				0: ; // reset values stay
				1: apply_regs('0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: apply_regs(33'h0_FFFF_FFFF, '0, '0, '0, '0, '0, '0, '0);
				3: apply_regs(33'h1_0000_0000, 16'd655, 16'd2000, 16'd2000, 16'd20000,
					16'd500, 16'd3000, 16'd40000);
				4: apply_regs({1'b1, $urandom}, factor_t'($urandom_range(0, 3000)),
					16'hFFFF, factor_t'($urandom), 16'd20000,
					16'hFFFF, factor_t'($urandom), 16'd9000);
				5: apply_regs({1'b0, $urandom}, factor_t'($urandom), factor_t'($urandom),
					factor_t'($urandom), factor_t'($urandom), factor_t'($urandom),
					factor_t'($urandom), factor_t'($urandom));
				6: apply_regs('0, 16'd655, 16'd1311, 16'd1311, 16'd13107,
					16'd1311, 16'd1311, 16'd13107);
				default: begin
					case ($urandom_range(0, 2))
						0: sv = '0;
						1: sv = {1'b0, $urandom};
						default: sv = {1'b1, $urandom};
					endcase
					apply_regs(sv,
						($urandom_range(0, 1) == 0) ? factor_t'($urandom) :
							factor_t'($urandom_range(0, 2000)),
						factor_t'($urandom_range(0, 8000)), factor_t'($urandom_range(0, 8000)),
						factor_t'($urandom), factor_t'($urandom_range(0, 8000)),
						factor_t'($urandom_range(0, 8000)), factor_t'($urandom));
				end
			endcase

			// directed bars
			if (k == 0) begin
				drive_bar(mk(1'b0, price_t'(100 << 16), price_t'(90 << 16))); // no series yet
				drive_bar(mk(1'b0, price_t'(105 << 16), price_t'(95 << 16))); // auto long
				drive_bar(mk(1'b0, price_t'(110 << 16), price_t'(100 << 16)));
				drive_bar(mk(1'b0, price_t'(108 << 16), price_t'(80 << 16)));  // long to short
				drive_bar(mk(1'b0, price_t'(90 << 16), price_t'(70 << 16)));
				drive_bar(mk(1'b0, price_t'(120 << 16), price_t'(100 << 16))); // short to long
				drive_bar(mk(1'b1, price_t'(100 << 16), price_t'(90 << 16)));
				drive_bar(mk(1'b0, price_t'(95 << 16), price_t'(80 << 16)));   // auto short
				drive_bar(mk(1'b0, price_t'(94 << 16), price_t'(85 << 16)));
				drive_bar(mk(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
				drive_bar(mk(1'b0, 32'hFFFF_FFFF, 32'h0000_0000));
				drive_bar(mk(1'b0, 32'h0000_0000, 32'h0000_0000));
				drive_bar(mk(1'b1, price_t'(50 << 16), price_t'(60 << 16)));   // high below low
				drive_bar(mk(1'b0, price_t'(40 << 16), price_t'(70 << 16)));
				drive_bar(mk(1'b0, 32'h0000_0000, 32'hFFFF_FFFF));
				drive_bar(mk(1'b1, 32'h0000_0000, 32'h0000_0000));
				drive_bar(mk(1'b0, 32'h0000_0000, 32'h0000_0000));             // flat: long
			end else if (k == 1) begin
				// reversal near the top: the offset pushes the stop past the largest price
				drive_bar(mk(1'b1, 32'hFFFF_0000, 32'hFFFE_0000));
				drive_bar(mk(1'b0, 32'hFFFF_FFFF, 32'hFFFF_8000));
				drive_bar(mk(1'b0, 32'hFFFF_F000, 32'h0001_0000));
			end else if (k == 3) begin
				// most negative start gives the largest stop, then a short to long reversal
				drive_bar(mk(1'b1, price_t'(10 << 16), price_t'(9 << 16)));
				drive_bar(mk(1'b0, price_t'(11 << 16), price_t'(10 << 16)));
				drive_bar(mk(1'b0, 32'hFFFF_FFFF, price_t'(5 << 16)));
			end

			// random part: mostly well-formed series, some raw noise
			target = bars_sent + BARS_PER_SETTING;
			while (bars_sent < target) begin
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 3)) begin
						b = mk($urandom_range(0, 3) == 0, $urandom, $urandom);
						drive_bar(b);
					end
				end else begin
					case ($urandom_range(0, 6))
						0:       walk_mid = $urandom_range(0, 1 << 20);
						1:       walk_mid = PRICE_TOP - $urandom_range(0, 1 << 20);
						default: walk_mid = $urandom;
					endcase
					case ($urandom_range(0, 3))
						0:       walk_span = $urandom_range(1, 64);
						1:       walk_span = $urandom_range(64, 1 << 16);
						2:       walk_span = $urandom_range(1 << 16, 1 << 24);
						default: walk_span = $urandom_range(1 << 24, 1 << 28);
					endcase
					walk_drift = longint'($urandom_range(0, walk_span)) / 2;
					if ($urandom_range(0, 1) == 0)
						walk_drift = -walk_drift;
					series_len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 5) :
						$urandom_range(6, 60);
					next_walk(1'b1, b);
					drive_bar(b);
					repeat (series_len - 1) begin
						next_walk(1'b0, b);
						drive_bar(b);
					end
				end
			end
		end

		settle();
		$display("%0d bars driven over %0d register settings, directed cases then random walks",
			bars_sent, SETTING_COUNT);
		$display("%0d stops compared, %0d of them in short position", stops_checked,
			shorts_seen);
		if (stop_errors == 0 && stops_waiting == 0)
			$display("[parabolic_sar_extended_unit] OK");
		else
			$display("[parabolic_sar_extended_unit] ERROR");
		$finish;
	end

endmodule
